### design/lens_distortion_plane_remap_macros.svh
// Assertion macros for the lens distortion remap block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LENS_DISTORTION_PLANE_REMAP_MACROS_SVH
`define LENS_DISTORTION_PLANE_REMAP_MACROS_SVH
`ifndef SYNTHESIS
`define LDPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ldpr assertion failed");
`define LDPR_NEVER(lbl, clk, rstn, cond) \
  `LDPR_ASSERT(lbl, clk, rstn, !(cond))
`else
`define LDPR_ASSERT(lbl, clk, rstn, prop)
`define LDPR_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### design/ldpr_pkg.sv
// Shared types and constants of the lens distortion remap block.
// No dependencies.
package ldpr_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPW     = 1;

  localparam logic [7:0] GRAY_LEVEL = 8'd128;
  localparam logic [7:0] TENTHS     = 8'd10;

  typedef enum logic [1:0] {
    CMD_LOAD_TABLE = 2'd0,
    CMD_LOAD_PIXEL = 2'd1,
    CMD_REQUEST    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PIXEL_SCALE  = 3'd2,
    CFG_HEAD_X       = 3'd3,
    CFG_HEAD_Y       = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TABLE,
    KIND_PIXEL,
    KIND_GRAY,
    KIND_REMAP
  } kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TBL,
    BK_COPY,
    BK_DIVX,
    BK_DIVY,
    BK_EDGE,
    BK_FETCH,
    BK_DIVT,
    BK_DIVB,
    BK_DIVO
  } back_state_e;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [3:0]  scale;
    logic [13:0] head_x;
    logic [13:0] head_y;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [9:0]       row;
    logic [9:0]       col;
    logic [7:0]       pixel;
    logic [11:0]      off_x;
    logic [11:0]      off_y;
    logic [IDX_W-1:0] t_row;
    logic [IDX_W-1:0] t_col;
    logic             neg_x;
    logic             neg_y;
  } entry_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [15:0] quot;
    logic [7:0]  rem;
  } div_rsp_t;

endpackage

### design/ldpr_front.sv
// Front end: classifies each request and precomputes table indices.
// Depends on ldpr_pkg.
module ldpr_front #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned TABLE_COLS = 512,
  parameter int unsigned TABLE_ROWS = 512
) (
  input  ldpr_pkg::cfg_t   cfg_i,
  input  logic [1:0]       cmd_i,
  input  logic [9:0]       row_i,
  input  logic [9:0]       col_i,
  input  logic [7:0]       pixel_in_i,
  input  logic [11:0]      offset_x_i,
  input  logic [11:0]      offset_y_i,
  output ldpr_pkg::entry_t entry_o
);

  localparam logic [12:0] MaxD = 13'(MAX_DIM);
  localparam logic [12:0] TRow = 13'(TABLE_ROWS);
  localparam logic [12:0] TCol = 13'(TABLE_COLS);

  function automatic logic [ldpr_pkg::IDX_W-1:0] tidx(
    input logic [9:0]  pos,
    input logic [13:0] head,
    input logic [3:0]  s,
    input logic [12:0] lim
  );
    logic signed [15:0] diff;
    logic [14:0]        mag;
    logic [18:0]        prod;
    logic [14:0]        idx;
    diff = $signed({2'b00, pos, 4'b0000}) - $signed({2'b00, head});
    mag  = diff[15] ? 15'(-diff) : diff[14:0];
    prod = 19'(mag) * 19'(s);
    idx  = prod[18:4];
    if (idx >= 15'(lim)) begin
      idx = 15'(lim) - 15'd1;
    end
    return ldpr_pkg::IDX_W'(idx);
  endfunction

  logic [12:0] w_c, h_c;
  logic [3:0]  s_c;

  always_comb begin
    w_c = ({2'b00, cfg_i.width} > MaxD) ? MaxD : {2'b00, cfg_i.width};
    h_c = ({2'b00, cfg_i.height} > MaxD) ? MaxD : {2'b00, cfg_i.height};
    s_c = (cfg_i.scale == 4'd0) ? 4'd1 : cfg_i.scale;

    entry_o.kind  = ldpr_pkg::KIND_NONE;
    entry_o.row   = row_i;
    entry_o.col   = col_i;
    entry_o.pixel = pixel_in_i;
    entry_o.off_x = offset_x_i;
    entry_o.off_y = offset_y_i;
    entry_o.t_row = tidx(row_i, cfg_i.head_y, s_c, TRow);
    entry_o.t_col = tidx(col_i, cfg_i.head_x, s_c, TCol);
    entry_o.neg_x = col_i < cfg_i.head_x[13:4];
    entry_o.neg_y = row_i < cfg_i.head_y[13:4];

    case (cmd_i)
      ldpr_pkg::CMD_LOAD_TABLE: begin
        if ({3'b000, row_i} < TRow && {3'b000, col_i} < TCol) begin
          entry_o.kind = ldpr_pkg::KIND_TABLE;
        end
      end
      ldpr_pkg::CMD_LOAD_PIXEL: begin
        if ({3'b000, row_i} < MaxD && {3'b000, col_i} < MaxD) begin
          entry_o.kind = ldpr_pkg::KIND_PIXEL;
        end
      end
      ldpr_pkg::CMD_REQUEST: begin
        if ({3'b000, row_i} >= h_c || {3'b000, col_i} >= w_c) begin
          entry_o.kind = ldpr_pkg::KIND_GRAY;
        end else begin
          entry_o.kind = ldpr_pkg::KIND_REMAP;
        end
      end
      default: entry_o.kind = ldpr_pkg::KIND_NONE;
    endcase
  end

endmodule

### design/ldpr_queue.sv
// Two-entry request queue between front and back end.
// Depends on ldpr_pkg.
module ldpr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ldpr_pkg::entry_t entry_i,
  input  logic             pop_i,
  output ldpr_pkg::entry_t entry_o,
  output logic             empty_o,
  output logic             full_o
);

  ldpr_pkg::entry_t             mem_q [ldpr_pkg::Q_DEPTH];
  logic [ldpr_pkg::QPW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [ldpr_pkg::QPW:0]       cnt_q, cnt_d;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (ldpr_pkg::QPW+1)'(ldpr_pkg::Q_DEPTH);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (ldpr_pkg::QPW+1)'(push_i) - (ldpr_pkg::QPW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

### design/ldpr_div.sv
// Radix-2 restoring divider, 16-bit dividend by 8-bit divisor.
// Depends on ldpr_pkg.
module ldpr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        dividend_i,
  input  logic [7:0]         divisor_i,
  output ldpr_pkg::div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [7:0]  rem_q, den_q;
  logic [15:0] quo_q;
  logic [8:0]  trial;
  logic        ge;

  assign trial = {rem_q, quo_q[15]};
  assign ge    = trial >= {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

endmodule

### design/ldpr_back.sv
// Back end: frame store, offset table, border handling and bilinear blend.
// Depends on ldpr_pkg, ldpr_div and the assertion macro header.
`include "lens_distortion_plane_remap_macros.svh"
module ldpr_back #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned TABLE_COLS = 512,
  parameter int unsigned TABLE_ROWS = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ldpr_pkg::cfg_t   cfg_i,
  input  logic             q_empty_i,
  input  ldpr_pkg::entry_t q_entry_i,
  output logic             pop_o,
  output logic [7:0]       pixel_out_o,
  output logic             filled_gray_o,
  output logic             done_o
);

  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned FDEP  = MAX_DIM * MAX_DIM;
  localparam int unsigned FAW   = $clog2(FDEP);
  localparam int unsigned TDEP  = TABLE_ROWS * TABLE_COLS;
  localparam int unsigned TAW   = $clog2(TDEP);
  localparam logic [12:0] MaxD  = 13'(MAX_DIM);

  ldpr_pkg::back_state_e state_q, state_d;

  logic [7:0]  frame_mem [FDEP];
  logic [23:0] tbl_mem [TDEP];
  logic [7:0]  frm_rdata_q;
  logic [23:0] tbl_rdata_q;

  logic            frm_we, frm_re, tbl_we, tbl_re;
  logic [FAW-1:0]  frm_waddr, frm_raddr;
  logic [TAW-1:0]  tbl_waddr, tbl_raddr;

  logic               div_start;
  logic [15:0]        div_dividend;
  ldpr_pkg::div_rsp_t div_rsp;
  logic               launched_q;
  logic [2:0]         fetch_q;

  logic               res_load, res_gray;
  logic [7:0]         res_pix;
  logic               res_valid_q, res_gray_q;
  logic [7:0]         res_pix_q;

  logic [9:0]         h_q, w_q;
  logic               negx_q, negy_q;
  logic signed [12:0] dx_q, dy_q;
  logic signed [9:0]  ix_q, iy_q;
  logic [7:0]         fx_q, fy_q;
  logic [AW-1:0]      rt_q, rb_q, cl_q, cr_q;
  logic [7:0]         p_q [4];
  logic [7:0]         pt_q, pb_q;

  logic [12:0]        w_c, h_c;
  logic [3:0]         s_c;
  logic [7:0]         f_c;
  logic signed [12:0] dx_c, dy_c, sel_d;
  logic               zero_off;
  logic signed [9:0]  split_i;
  logic [7:0]         split_f;
  logic signed [12:0] r1, r2, c1, c2, hs, ws;
  logic               outside, by_one, edge_gray;
  logic [AW-1:0]      fr_row, fr_col;

  function automatic logic [FAW-1:0] pix_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    return FAW'(r) * FAW'(MAX_DIM) + FAW'(c);
  endfunction

  ldpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (f_c),
    .rsp_o      (div_rsp)
  );

  // Datapath terms
  always_comb begin
    w_c = ({2'b00, cfg_i.width} > MaxD) ? MaxD : {2'b00, cfg_i.width};
    h_c = ({2'b00, cfg_i.height} > MaxD) ? MaxD : {2'b00, cfg_i.height};
    s_c = (cfg_i.scale == 4'd0) ? 4'd1 : cfg_i.scale;
    f_c = 8'(s_c) * ldpr_pkg::TENTHS;
    hs  = $signed(h_c);
    ws  = $signed(w_c);

    dx_c = {tbl_rdata_q[11], tbl_rdata_q[11:0]};
    dy_c = {tbl_rdata_q[23], tbl_rdata_q[23:12]};
    if (negx_q) dx_c = -dx_c;
    if (negy_q) dy_c = -dy_c;
    zero_off = (dx_c == '0) && (dy_c == '0);

    // Floor split of the offset under division
    sel_d = (state_q == ldpr_pkg::BK_DIVY) ? dy_q : dx_q;
    if (sel_d[12] && div_rsp.rem != 8'd0) begin
      split_i = -$signed(div_rsp.quot[9:0]) - 10'sd1;
      split_f = f_c - div_rsp.rem;
    end else if (sel_d[12]) begin
      split_i = -$signed(div_rsp.quot[9:0]);
      split_f = 8'd0;
    end else begin
      split_i = $signed(div_rsp.quot[9:0]);
      split_f = div_rsp.rem;
    end

    r1 = $signed({3'b000, h_q}) + {{3{iy_q[9]}}, iy_q};
    r2 = r1 + 13'sd1;
    c1 = $signed({3'b000, w_q}) + {{3{ix_q[9]}}, ix_q};
    c2 = c1 + 13'sd1;
    outside = r1 < 0 || r2 >= hs || c1 < 0 || c2 >= ws;
    by_one  = ((r2 == 0 || r2 == hs) && c2 > 0 && c2 < ws) ||
              ((c2 == 0 || c2 == ws) && r2 > 0 && r2 < hs);
    edge_gray = outside && !by_one;

    case (fetch_q)
      3'd0:    begin fr_row = rt_q; fr_col = cl_q; end
      3'd1:    begin fr_row = rt_q; fr_col = cr_q; end
      3'd2:    begin fr_row = rb_q; fr_col = cl_q; end
      default: begin fr_row = rb_q; fr_col = cr_q; end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldpr_pkg::BK_IDLE: begin
        if (!q_empty_i && q_entry_i.kind == ldpr_pkg::KIND_REMAP) begin
          state_d = ldpr_pkg::BK_TBL;
        end
      end
      ldpr_pkg::BK_TBL:   state_d = zero_off ? ldpr_pkg::BK_COPY : ldpr_pkg::BK_DIVX;
      ldpr_pkg::BK_COPY:  state_d = ldpr_pkg::BK_IDLE;
      ldpr_pkg::BK_DIVX:  if (div_rsp.done) state_d = ldpr_pkg::BK_DIVY;
      ldpr_pkg::BK_DIVY:  if (div_rsp.done) state_d = ldpr_pkg::BK_EDGE;
      ldpr_pkg::BK_EDGE:  state_d = edge_gray ? ldpr_pkg::BK_IDLE : ldpr_pkg::BK_FETCH;
      ldpr_pkg::BK_FETCH: if (fetch_q == 3'd4) state_d = ldpr_pkg::BK_DIVT;
      ldpr_pkg::BK_DIVT:  if (div_rsp.done) state_d = ldpr_pkg::BK_DIVB;
      ldpr_pkg::BK_DIVB:  if (div_rsp.done) state_d = ldpr_pkg::BK_DIVO;
      ldpr_pkg::BK_DIVO:  if (div_rsp.done) state_d = ldpr_pkg::BK_IDLE;
      default:            state_d = ldpr_pkg::BK_IDLE;
    endcase
  end

  // Outputs of each state
  always_comb begin
    pop_o        = 1'b0;
    frm_we       = 1'b0;
    frm_re       = 1'b0;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    frm_waddr    = pix_addr(AW'(q_entry_i.row), AW'(q_entry_i.col));
    frm_raddr    = pix_addr(fr_row, fr_col);
    tbl_waddr    = TAW'(q_entry_i.row) * TAW'(TABLE_COLS) + TAW'(q_entry_i.col);
    tbl_raddr    = TAW'(q_entry_i.t_row) * TAW'(TABLE_COLS) + TAW'(q_entry_i.t_col);
    div_start    = 1'b0;
    div_dividend = '0;
    res_load     = 1'b0;
    res_pix      = ldpr_pkg::GRAY_LEVEL;
    res_gray     = 1'b1;
    case (state_q)
      ldpr_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          case (q_entry_i.kind)
            ldpr_pkg::KIND_TABLE: tbl_we   = 1'b1;
            ldpr_pkg::KIND_PIXEL: frm_we   = 1'b1;
            ldpr_pkg::KIND_GRAY:  res_load = 1'b1;
            ldpr_pkg::KIND_REMAP: tbl_re   = 1'b1;
            default: ;
          endcase
        end
      end
      ldpr_pkg::BK_TBL: begin
        if (zero_off) begin
          frm_re    = 1'b1;
          frm_raddr = pix_addr(AW'(h_q), AW'(w_q));
        end
      end
      ldpr_pkg::BK_COPY: begin
        res_load = 1'b1;
        res_pix  = frm_rdata_q;
        res_gray = 1'b0;
      end
      ldpr_pkg::BK_DIVX: begin
        div_start    = !launched_q;
        div_dividend = 16'(dx_q[12] ? -dx_q : dx_q);
      end
      ldpr_pkg::BK_DIVY: begin
        div_start    = !launched_q;
        div_dividend = 16'(dy_q[12] ? -dy_q : dy_q);
      end
      ldpr_pkg::BK_EDGE: begin
        res_load = edge_gray;
      end
      ldpr_pkg::BK_FETCH: begin
        frm_re = fetch_q < 3'd4;
      end
      ldpr_pkg::BK_DIVT: begin
        div_start    = !launched_q;
        div_dividend = 16'(17'(p_q[0]) * 17'(f_c - fx_q) + 17'(p_q[1]) * 17'(fx_q));
      end
      ldpr_pkg::BK_DIVB: begin
        div_start    = !launched_q;
        div_dividend = 16'(17'(p_q[2]) * 17'(f_c - fx_q) + 17'(p_q[3]) * 17'(fx_q));
      end
      ldpr_pkg::BK_DIVO: begin
        div_start    = !launched_q;
        div_dividend = 16'(17'(pt_q) * 17'(f_c - fy_q) + 17'(pb_q) * 17'(fy_q));
        res_load     = div_rsp.done;
        res_pix      = div_rsp.quot[7:0];
        res_gray     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (frm_we) frame_mem[frm_waddr] <= q_entry_i.pixel;
    if (frm_re) frm_rdata_q <= frame_mem[frm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= {q_entry_i.off_y, q_entry_i.off_x};
    if (tbl_re) tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldpr_pkg::BK_IDLE;
      launched_q  <= 1'b0;
      fetch_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_load;
      if (div_start) begin
        launched_q <= 1'b1;
      end else if (div_rsp.done) begin
        launched_q <= 1'b0;
      end
      fetch_q <= (state_q == ldpr_pkg::BK_FETCH) ? fetch_q + 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_pix_q  <= res_pix;
      res_gray_q <= res_gray;
    end
    case (state_q)
      ldpr_pkg::BK_IDLE: begin
        h_q    <= q_entry_i.row;
        w_q    <= q_entry_i.col;
        negx_q <= q_entry_i.neg_x;
        negy_q <= q_entry_i.neg_y;
      end
      ldpr_pkg::BK_TBL: begin
        dx_q <= dx_c;
        dy_q <= dy_c;
      end
      ldpr_pkg::BK_DIVX: begin
        if (div_rsp.done) begin
          ix_q <= split_i;
          fx_q <= split_f;
        end
      end
      ldpr_pkg::BK_DIVY: begin
        if (div_rsp.done) begin
          iy_q <= split_i;
          fy_q <= split_f;
        end
      end
      ldpr_pkg::BK_EDGE: begin
        // Repeat the inside row or column where the square hangs over by one
        rt_q <= AW'((r1 < 0) ? r2 : r1);
        rb_q <= AW'((r2 >= hs) ? r1 : r2);
        cl_q <= AW'((c1 < 0) ? c2 : c1);
        cr_q <= AW'((c2 >= ws) ? c1 : c2);
      end
      ldpr_pkg::BK_FETCH: begin
        if (fetch_q != 3'd0) p_q[2'(fetch_q - 3'd1)] <= frm_rdata_q;
      end
      ldpr_pkg::BK_DIVT: if (div_rsp.done) pt_q <= div_rsp.quot[7:0];
      ldpr_pkg::BK_DIVB: if (div_rsp.done) pb_q <= div_rsp.quot[7:0];
      default: ;
    endcase
  end

  assign done_o        = res_valid_q;
  assign pixel_out_o   = res_pix_q;
  assign filled_gray_o = res_gray_q;

  `LDPR_NEVER(a_div_overlap, clk_i, rst_ni, div_start && div_rsp.busy)
  `LDPR_ASSERT(a_gray_level, clk_i, rst_ni, res_valid_q && res_gray_q |-> res_pix_q == ldpr_pkg::GRAY_LEVEL)
  `LDPR_ASSERT(a_fetch_bound, clk_i, rst_ni, state_q == ldpr_pkg::BK_FETCH |-> fetch_q <= 3'd4)
  `LDPR_ASSERT(a_div_done_state, clk_i, rst_ni, div_rsp.done |-> (state_q == ldpr_pkg::BK_DIVX || state_q == ldpr_pkg::BK_DIVY || state_q == ldpr_pkg::BK_DIVT || state_q == ldpr_pkg::BK_DIVB || state_q == ldpr_pkg::BK_DIVO))

endmodule

### design/lens_distortion_plane_remap.sv
// Top level of the lens distortion plane remap: config registers, front end,
// request queue and back end. Depends on ldpr_pkg, ldpr_front, ldpr_queue, ldpr_back.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  request   | start / busy        | cmd_i row_i col_i pixel_in_i offset_x_i offset_y_i
//  result    | done_o (one cycle)  | pixel_out_o filled_gray_o
//  config    | cfg_we_i            | cfg_idx_i cfg_wdata_i
//
// Table and pixel loads and out-of-frame requests are handled from the idle state. A zero-offset
// request reads its table entry and copies one frame pixel; an interpolated one takes five passes
// of the shared serial divider and four frame reads.
// Reset clears control only; both stores are undefined until written.
// busy is high while the two-entry queue is full; results cannot be stalled.
module lens_distortion_plane_remap #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned TABLE_COLS = 512,
  parameter int unsigned TABLE_ROWS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  row_i,
  input  logic [9:0]  col_i,
  input  logic [7:0]  pixel_in_i,
  input  logic [11:0] offset_x_i,
  input  logic [11:0] offset_y_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  output logic [7:0]  pixel_out_o,
  output logic        filled_gray_o,
  output logic        done_o
);

  ldpr_pkg::cfg_t   cfg_q;
  ldpr_pkg::entry_t front_entry, q_entry;
  logic             q_empty, q_full, q_pop, q_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 11'd640;
      cfg_q.height <= 11'd480;
      cfg_q.scale  <= 4'd1;
      cfg_q.head_x <= 14'd5120;
      cfg_q.head_y <= 14'd3840;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ldpr_pkg::CFG_FRAME_WIDTH:  cfg_q.width  <= cfg_wdata_i[10:0];
        ldpr_pkg::CFG_FRAME_HEIGHT: cfg_q.height <= cfg_wdata_i[10:0];
        ldpr_pkg::CFG_PIXEL_SCALE:  cfg_q.scale  <= cfg_wdata_i[3:0];
        ldpr_pkg::CFG_HEAD_X:       cfg_q.head_x <= cfg_wdata_i;
        ldpr_pkg::CFG_HEAD_Y:       cfg_q.head_y <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;

  ldpr_front #(
    .MAX_DIM    (MAX_DIM),
    .TABLE_COLS (TABLE_COLS),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_front (
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .pixel_in_i (pixel_in_i),
    .offset_x_i (offset_x_i),
    .offset_y_i (offset_y_i),
    .entry_o    (front_entry)
  );

  ldpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (q_pop),
    .entry_o (q_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ldpr_back #(
    .MAX_DIM    (MAX_DIM),
    .TABLE_COLS (TABLE_COLS),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_entry),
    .pop_o         (q_pop),
    .pixel_out_o   (pixel_out_o),
    .filled_gray_o (filled_gray_o),
    .done_o        (done_o)
  );

endmodule

### bench/lens_distortion_plane_remap_check.sv
// Checker for the lens distortion plane remap: watches request, config and result ports,
// predicts each corrected pixel from its own copy of stores and registers, and compares.
// Depends on ldpr_pkg.
`timescale 1ns / 100ps

module lens_distortion_plane_remap_check
  import ldpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  row_i,
  input  logic [9:0]  col_i,
  input  logic [7:0]  pixel_in_i,
  input  logic [11:0] offset_x_i,
  input  logic [11:0] offset_y_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic [7:0]  pixel_out_i,
  input  logic        filled_gray_i,
  input  logic        done_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          gray_results_o
);

  localparam int FrameDim = 1024;
  localparam int TabRows  = 512;
  localparam int TabCols  = 512;

  typedef struct {
    logic [7:0] pixel;
    logic       gray;
  } remap_out_t;

  logic [7:0]  frame_px [int];
  logic [23:0] offset_mem [int];
  remap_out_t  remap_fifo [$];

  logic [10:0] width_q, height_q;
  logic [3:0]  scale_q;
  logic [13:0] head_x_q, head_y_q;

  assign pending_o = remap_fifo.size();

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic int step_index(int pos, int head_q4, int s, int limit);
    int diff;
    int mag;
    diff = pos * 16 - head_q4;
    mag  = (diff < 0 ? -diff : diff) * s;
    mag  = mag >> 4;
    return mag > limit - 1 ? limit - 1 : mag;
  endfunction

  function automatic int floor_quot(int n, int d);
    return n >= 0 ? n / d : -((-n + d - 1) / d);
  endfunction

  function automatic int px_at(int r, int c);
    return frame_px.exists(r * FrameDim + c) ? int'(frame_px[r * FrameDim + c]) : 0;
  endfunction

  function automatic remap_out_t corrected_pixel(int r, int c);
    remap_out_t res;
    int wd, ht, s, f, dx, dy, ix, iy, fx, fy, r1, r2, c1, c2, rt, rb, cl, cr;
    int p1, p2, p3, p4, pt, pb, key;
    logic [23:0] ent;
    logic outside, by_one;
    res.pixel = GRAY_LEVEL;
    res.gray  = 1'b1;
    wd = width_q > FrameDim ? FrameDim : int'(width_q);
    ht = height_q > FrameDim ? FrameDim : int'(height_q);
    if (r >= ht || c >= wd) return res;
    s = scale_q == 0 ? 1 : int'(scale_q);
    f = 10 * s;
    key = step_index(r, head_y_q, s, TabRows) * TabCols + step_index(c, head_x_q, s, TabCols);
    ent = offset_mem.exists(key) ? offset_mem[key] : 24'd0;
    dx = int'($signed(ent[11:0]));
    dy = int'($signed(ent[23:12]));
    if (c < int'(head_x_q >> 4)) dx = -dx;
    if (r < int'(head_y_q >> 4)) dy = -dy;
    if (dx == 0 && dy == 0) begin
      res.pixel = px_at(r, c);
      res.gray  = 1'b0;
      return res;
    end
    ix = floor_quot(dx, f);
    iy = floor_quot(dy, f);
    r1 = r + iy; r2 = r1 + 1;
    c1 = c + ix; c2 = c1 + 1;
    outside = r1 < 0 || r2 >= ht || c1 < 0 || c2 >= wd;
    by_one = ((r2 == 0 || r2 == ht) && c2 > 0 && c2 < wd) ||
             ((c2 == 0 || c2 == wd) && r2 > 0 && r2 < ht);
    if (outside && !by_one) return res;
    rt = r1 < 0 ? r2 : r1;
    rb = r2 >= ht ? r1 : r2;
    cl = c1 < 0 ? c2 : c1;
    cr = c2 >= wd ? c1 : c2;
    p1 = px_at(rt, cl); p2 = px_at(rt, cr);
    p3 = px_at(rb, cl); p4 = px_at(rb, cr);
    fx = dx - ix * f;
    fy = dy - iy * f;
    pt = (p1 * (f - fx) + p2 * fx) / f;
    pb = (p3 * (f - fx) + p4 * fx) / f;
    res.pixel = 8'((pt * (f - fy) + pb * fy) / f);
    res.gray  = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      scale_q  <= 4'd1;
      head_x_q <= 14'd5120;
      head_y_q <= 14'd3840;
      remap_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[10:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i[10:0];
          CFG_PIXEL_SCALE:  scale_q  <= cfg_wdata_i[3:0];
          CFG_HEAD_X:       head_x_q <= cfg_wdata_i;
          CFG_HEAD_Y:       head_y_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // stores update in request order, so predict at acceptance
      if (start && !busy) begin
        case (cmd_i)
          CMD_LOAD_TABLE: begin
            if (row_i < TabRows && col_i < TabCols)
              offset_mem[int'(row_i) * TabCols + int'(col_i)] = {offset_y_i, offset_x_i};
          end
          CMD_LOAD_PIXEL: frame_px[int'(row_i) * FrameDim + int'(col_i)] = pixel_in_i;
          CMD_REQUEST:    remap_fifo.push_back(corrected_pixel(row_i, col_i));
          default: ;
        endcase
      end
      if (done_i) begin
        results_o++;
        if (filled_gray_i) gray_results_o++;
        if (remap_fifo.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          if (pixel_out_i !== remap_fifo[0].pixel)
            report_mismatch($sformatf("pixel_out %0d, want %0d", pixel_out_i,
                                      remap_fifo[0].pixel));
          if (filled_gray_i !== remap_fifo[0].gray)
            report_mismatch($sformatf("filled_gray %0b, want %0b", filled_gray_i,
                                      remap_fifo[0].gray));
          remap_fifo.pop_front();
        end
      end
    end
  end

endmodule

### bench/lens_distortion_plane_remap_test.sv
// Top of the lens distortion remap bench: clock, reset, request and config stimulus,
// verdict. Depends on ldpr_pkg, lens_distortion_plane_remap, lens_distortion_plane_remap_check.
`timescale 1ns / 100ps

module lens_distortion_plane_remap_test;
  import ldpr_pkg::*;

  localparam int FrameDim = 1024;
  localparam int TabRows  = 512;
  localparam int TabCols  = 512;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [9:0]  row_i, col_i;
  logic [7:0]  pixel_in_i;
  logic [11:0] offset_x_i, offset_y_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [13:0] cfg_wdata_i;
  logic [7:0]  pixel_out_o;
  logic        filled_gray_o;
  logic        done_o;
  int          fail_count, pending, results, gray_results;

  bit px_written [int];
  bit tbl_written [int];
  int items_sent;
  int cur_w, cur_h, cur_scale, cur_hx, cur_hy;

  always #10 clk_i = ~clk_i;

  lens_distortion_plane_remap i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .row_i, .col_i, .pixel_in_i,
    .offset_x_i, .offset_y_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pixel_out_o, .filled_gray_o, .done_o
  );

  lens_distortion_plane_remap_check i_check (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .row_i, .col_i, .pixel_in_i,
    .offset_x_i, .offset_y_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pixel_out_i(pixel_out_o), .filled_gray_i(filled_gray_o), .done_i(done_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .gray_results_o(gray_results)
  );

  function automatic int tab_step(int pos, int head_q4, int limit);
    int diff;
    int s;
    s = cur_scale == 0 ? 1 : cur_scale;
    diff = pos * 16 - head_q4;
    diff = ((diff < 0 ? -diff : diff) * s) >> 4;
    return diff > limit - 1 ? limit - 1 : diff;
  endfunction

  function automatic int tab_key(int r, int c);
    return tab_step(r, cur_hy, TabRows) * TabCols + tab_step(c, cur_hx, TabCols);
  endfunction

  task automatic send_request(logic [1:0] c, int r, int cl, int p, int ox, int oy);
    // idle bursts everywhere but the tail of the run
    if (items_sent < 1300 && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start      <= 1'b1;
    cmd_i      <= c;
    row_i      <= r[9:0];
    col_i      <= cl[9:0];
    pixel_in_i <= p[7:0];
    offset_x_i <= ox[11:0];
    offset_y_i <= oy[11:0];
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    items_sent++;
    if (c == CMD_LOAD_TABLE && r < TabRows && cl < TabCols) tbl_written[r * TabCols + cl] = 1;
    if (c == CMD_LOAD_PIXEL) px_written[r * FrameDim + cl] = 1;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // loads give no result; let the back end finish them
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[13:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // set up a phase and, when fill is set, load every pixel and table entry its requests can read
  task automatic set_frame(int w, int h, int s, int hx, int hy, bit fill);
    int key;
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_PIXEL_SCALE, s);
    write_reg(CFG_HEAD_X, hx);
    write_reg(CFG_HEAD_Y, hy);
    cur_w = w > FrameDim ? FrameDim : w;
    cur_h = h > FrameDim ? FrameDim : h;
    cur_scale = s; cur_hx = hx; cur_hy = hy;
    if (fill) begin
      for (int r = 0; r < cur_h; r++) begin
        for (int c = 0; c < cur_w; c++) begin
          if (!px_written.exists(r * FrameDim + c))
            send_request(CMD_LOAD_PIXEL, r, c, $urandom_range(0, 255), 0, 0);
          key = tab_key(r, c);
          if (!tbl_written.exists(key))
            send_request(CMD_LOAD_TABLE, key / TabCols, key % TabCols, 0,
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
      end
    end
  endtask

  task automatic request_with(int r, int c, int ox, int oy);
    int key;
    key = tab_key(r, c);
    send_request(CMD_LOAD_TABLE, key / TabCols, key % TabCols, 0, ox, oy);
    send_request(CMD_REQUEST, r, c, 0, 0, 0);
  endtask

  task automatic random_small_item;
    int r, c;
    case ($urandom_range(0, 19))
      12, 13, 14: begin
        r = $urandom_range(0, cur_h > 0 ? cur_h - 1 : 0);
        c = $urandom_range(0, cur_w > 0 ? cur_w - 1 : 0);
        r = tab_key(r, c);
        send_request(CMD_LOAD_TABLE, r / TabCols, r % TabCols, 0,
                     $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      15: send_request(CMD_LOAD_TABLE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095));
      16, 17: send_request(CMD_LOAD_PIXEL, $urandom_range(0, cur_h > 0 ? cur_h - 1 : 0),
                           $urandom_range(0, cur_w > 0 ? cur_w - 1 : 0),
                           $urandom_range(0, 255), 0, 0);
      18: send_request(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095));
      19: send_request(CMD_LOAD_PIXEL, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095));
      default: begin
        r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, cur_h + 1);
        c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, cur_w + 1);
        send_request(CMD_REQUEST, r, c, $urandom_range(0, 255),
                     $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    endcase
  endtask

  // large frames: keep offsets under one step so a request reads only its 3x3 patch
  task automatic random_large_request;
    int r, c;
    r = $urandom_range(0, 1023);
    c = $urandom_range(0, 1023);
    if ($urandom_range(0, 7) == 0) send_request(CMD_UNUSED, r, c, 0, 0, 0);
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (r + dr >= 0 && r + dr < FrameDim && c + dc >= 0 && c + dc < FrameDim)
          send_request(CMD_LOAD_PIXEL, r + dr, c + dc, $urandom_range(0, 255), 0, 0);
    if ($urandom_range(0, 5) == 0)
      request_with(r, c, 0, 0);
    else
      request_with(r, c, int'($urandom_range(0, 18)) - 9, int'($urandom_range(0, 18)) - 9);
  endtask

  initial begin
    #(40_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= CMD_LOAD_TABLE;
    row_i <= '0; col_i <= '0; pixel_in_i <= '0;
    offset_x_i <= '0; offset_y_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= CFG_FRAME_WIDTH; cfg_wdata_i <= '0;
    items_sent = 0;
    cur_w = 640; cur_h = 480; cur_scale = 1; cur_hx = 5120; cur_hy = 3840;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 8x6 frame, head at pixel center (3.5, 2.5)
    set_frame(8, 6, 1, 56, 40, 1'b1);
    send_request(CMD_UNUSED, 1023, 1023, 255, 2047, 2048);
    send_request(CMD_LOAD_TABLE, 1023, 5, 0, 4095, 4095);
    send_request(CMD_LOAD_TABLE, 5, 512, 0, 4095, 4095);
    send_request(CMD_LOAD_PIXEL, 1023, 1023, 255, 0, 0);
    send_request(CMD_LOAD_PIXEL, 0, 0, 0, 0, 0);
    request_with(0, 0, 0, 0);
    request_with(2, 3, 5, -5);
    request_with(5, 7, 15, 15);
    request_with(0, 0, 5, 5);
    request_with(5, 7, -5, -5);
    request_with(3, 4, 2047, -2048);
    request_with(2, 3, -2048, 2047);
    request_with(4, 5, 10, 0);
    send_request(CMD_REQUEST, 6, 0, 0, 0, 0);
    send_request(CMD_REQUEST, 1023, 1023, 0, 0, 0);

    // random small frames, including degenerate sizes and register extremes
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_frame(1, 32, 0, 0, 0, 1'b1);
        1: set_frame(32, 1, 15, 16383, 16383, 1'b1);
        2: set_frame(0, 20, 8, 100, 100, 1'b1);
        default: set_frame($urandom_range(2, 32), $urandom_range(2, 32), $urandom_range(0, 15),
                           $urandom_range(0, 600), $urandom_range(0, 600), 1'b1);
      endcase
      repeat (160) random_small_item();
    end

    // full-size frames, oversized width and height registers
    set_frame(2047, 1024, 8, 0, 0, 1'b0);
    repeat (30) random_large_request();
    set_frame(1024, 2047, 1, 16383, 8191, 1'b0);
    repeat (30) random_large_request();

    drain();
    $display("%0d requests accepted, %0d corrected pixels checked (%0d gray fills)",
             items_sent, results, gray_results);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
